// ===== src/gprl_pkg.sv =====
// Shared types, constants and the arctangent table of the go-to-point regulator.
// No dependencies; every module of the block imports this package.
package gprl_pkg;

  localparam int COORD_BITS_DEF   = 18;
  localparam int ANGLE_BITS_DEF   = 16;
  localparam int CORDIC_STEPS_DEF = 16;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;

  // CORDIC working width; the error vector is prescaled to 2^SCALE_BITS
  localparam int XW         = 48;
  localparam int SCALE_BITS = 43;

  localparam logic [15:0] INV_GAIN_Q16    = 16'd39797;
  localparam logic [28:0] TWO_PI_MRAD_Q16 = 29'd411774832;
  localparam int          MRAD_W          = 12;
  localparam int          ROTP_W          = 28;

  localparam logic [1:0] STAT_REGULATING = 2'd0;
  localparam logic [1:0] STAT_AT_TARGET  = 2'd1;
  localparam logic [1:0] STAT_AT_WALL    = 2'd2;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_TRANS_GAIN  = 3'd0,
    REG_ROT_GAIN    = 3'd1,
    REG_ARRIVE      = 3'd2,
    REG_WALL        = 3'd3,
    REG_TRANS_LIMIT = 3'd4,
    REG_TRANS_STEP  = 3'd5,
    REG_ROT_LIMIT   = 3'd6,
    REG_ROT_STEP    = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic [15:0] trans_gain;
    logic [15:0] rot_gain;
    logic [11:0] arrive_radius_mm;
    logic [11:0] wall_offset_mm;
    logic [11:0] trans_limit;
    logic [7:0]  trans_step;
    logic [14:0] rot_limit;
    logic [9:0]  rot_step;
  } cfg_t;

  typedef enum logic [3:0] {
    S_IDLE, S_PREP, S_ITER, S_DIST1, S_DIST2, S_DECIDE,
    S_MUL1, S_MUL2, S_MUL3, S_FINISH
  } state_t;

  typedef struct packed {
    logic load;
    logic prep;
    logic iter;
    logic dist1;
    logic dist2;
    logic decide;
    logic mul1;
    logic mul2;
    logic mul3;
    logic finish;
  } dp_cmd_t;

  typedef struct packed {
    logic iter_last;
    logic out_busy;
  } dp_stat_t;

  // atan(2^-i) with a 32-bit full turn
  function automatic logic [31:0] atan_val(input logic [4:0] idx);
    logic [31:0] v;
    case (idx)
      5'd0:  v = 32'h20000000;
      5'd1:  v = 32'h12E4051E;
      5'd2:  v = 32'h09FB385B;
      5'd3:  v = 32'h051111D4;
      5'd4:  v = 32'h028B0D43;
      5'd5:  v = 32'h0145D7E1;
      5'd6:  v = 32'h00A2F61E;
      5'd7:  v = 32'h00517C55;
      5'd8:  v = 32'h0028BE53;
      5'd9:  v = 32'h00145F2F;
      5'd10: v = 32'h000A2F98;
      5'd11: v = 32'h000517CC;
      5'd12: v = 32'h00028BE6;
      5'd13: v = 32'h000145F3;
      5'd14: v = 32'h0000A2FA;
      5'd15: v = 32'h0000517D;
      5'd16: v = 32'h000028BE;
      5'd17: v = 32'h0000145F;
      5'd18: v = 32'h00000A30;
      5'd19: v = 32'h00000518;
      5'd20: v = 32'h0000028C;
      5'd21: v = 32'h00000146;
      5'd22: v = 32'h000000A3;
      5'd23: v = 32'h00000051;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

endpackage

// ===== src/gprl_in_if.sv =====
// Request channel carrying one pose/target request.
// Depends on nothing.
interface gprl_in_if #(
  parameter int COORD_BITS = 18,
  parameter int ANGLE_BITS = 16
);
  logic                  valid;
  logic                  ready;
  logic                  mode;
  logic [COORD_BITS-1:0] target_x_mm;
  logic [COORD_BITS-1:0] target_y_mm;
  logic [COORD_BITS-1:0] robot_x_mm;
  logic [COORD_BITS-1:0] robot_y_mm;
  logic [ANGLE_BITS-1:0] robot_heading;
  logic [ANGLE_BITS-1:0] target_heading;
  logic                  mirror_y;
  logic                  stop_short;

  modport source (output valid, mode, target_x_mm, target_y_mm, robot_x_mm, robot_y_mm,
                  robot_heading, target_heading, mirror_y, stop_short, input ready);
  modport sink (input valid, mode, target_x_mm, target_y_mm, robot_x_mm, robot_y_mm,
                robot_heading, target_heading, mirror_y, stop_short, output ready);
endinterface

// ===== src/gprl_out_if.sv =====
// Result channel carrying one speed command result.
// Depends on nothing.
interface gprl_out_if;
  logic        valid;
  logic        ready;
  logic [11:0] trans_cmd;
  logic        trans_written;
  logic [15:0] rot_cmd;
  logic [1:0]  status;

  modport source (output valid, trans_cmd, trans_written, rot_cmd, status, input ready);
  modport sink (input valid, trans_cmd, trans_written, rot_cmd, status, output ready);
endinterface

// ===== src/goto_point_rate_limited_regulator_core.sv =====
// Go-to-point regulator with ramped speed commands. One request is worked at a
// time: a move request runs through the iterative CORDIC vectoring unit, which does
// one micro-rotation a cycle, followed by three registered multiplier stages; a
// rotate request skips the CORDIC. The next request is taken while a finished
// result still waits at the output register.
// Configuration writes are taken at any time but belong to idle periods.
// Depends on gprl_pkg, gprl_in_if, gprl_out_if, gprl_ctrl and gprl_datapath.
module goto_point_rate_limited_regulator_core import gprl_pkg::*; #(
  parameter int COORD_BITS   = COORD_BITS_DEF,
  parameter int ANGLE_BITS   = ANGLE_BITS_DEF,
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  gprl_in_if.sink                in_ch,
  gprl_out_if.source             out_ch,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  cfg_t     cfg;
  dp_cmd_t  cmd;
  dp_stat_t stat;
  logic     in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.trans_gain       <= 16'd512;
      cfg.rot_gain         <= 16'd256;
      cfg.arrive_radius_mm <= 12'd100;
      cfg.wall_offset_mm   <= 12'd350;
      cfg.trans_limit      <= 12'd3000;
      cfg.trans_step       <= 8'd15;
      cfg.rot_limit        <= 15'd1571;
      cfg.rot_step         <= 10'd100;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_TRANS_GAIN:  cfg.trans_gain       <= cfg_data;
        REG_ROT_GAIN:    cfg.rot_gain         <= cfg_data;
        REG_ARRIVE:      cfg.arrive_radius_mm <= cfg_data[11:0];
        REG_WALL:        cfg.wall_offset_mm   <= cfg_data[11:0];
        REG_TRANS_LIMIT: cfg.trans_limit      <= cfg_data[11:0];
        REG_TRANS_STEP:  cfg.trans_step       <= cfg_data[7:0];
        REG_ROT_LIMIT:   cfg.rot_limit        <= cfg_data[14:0];
        REG_ROT_STEP:    cfg.rot_step         <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  assign in_ch.ready = in_ready;

  gprl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_mode  (in_ch.mode),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  gprl_datapath #(
    .COORD_BITS   (COORD_BITS),
    .ANGLE_BITS   (ANGLE_BITS),
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .cfg            (cfg),
    .mode           (in_ch.mode),
    .target_x_mm    (in_ch.target_x_mm),
    .target_y_mm    (in_ch.target_y_mm),
    .robot_x_mm     (in_ch.robot_x_mm),
    .robot_y_mm     (in_ch.robot_y_mm),
    .robot_heading  (in_ch.robot_heading),
    .target_heading (in_ch.target_heading),
    .mirror_y       (in_ch.mirror_y),
    .stop_short     (in_ch.stop_short),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .trans_cmd      (out_ch.trans_cmd),
    .trans_written  (out_ch.trans_written),
    .rot_cmd        (out_ch.rot_cmd),
    .status         (out_ch.status)
  );

`ifndef SYNTH
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("request accepted while a request is in work");

  a_stop_zero: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.status != STAT_REGULATING) |->
      (out_ch.trans_cmd == 12'd0 && out_ch.rot_cmd == 16'd0 && out_ch.trans_written))
    else $error("stop result carries a nonzero command");

  a_unwritten_zero: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && !out_ch.trans_written) |-> out_ch.trans_cmd == 12'd0)
    else $error("translation shown without being written");
`endif

endmodule

// ===== src/gprl_ctrl.sv =====
// Sequencer of the regulator: steps the datapath through one request.
// Depends on gprl_pkg.
module gprl_ctrl import gprl_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  input  logic     in_mode,
  output logic     in_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) state_next = in_mode ? S_DECIDE : S_PREP;
      end
      S_PREP:   state_next = S_ITER;
      S_ITER: begin
        if (stat.iter_last) state_next = S_DIST1;
      end
      S_DIST1:  state_next = S_DIST2;
      S_DIST2:  state_next = S_DECIDE;
      S_DECIDE: state_next = S_MUL1;
      S_MUL1:   state_next = S_MUL2;
      S_MUL2:   state_next = S_MUL3;
      S_MUL3:   state_next = S_FINISH;
      S_FINISH: begin
        if (!stat.out_busy) state_next = S_IDLE;
      end
      default:  state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      S_PREP:   cmd.prep   = 1'b1;
      S_ITER:   cmd.iter   = 1'b1;
      S_DIST1:  cmd.dist1  = 1'b1;
      S_DIST2:  cmd.dist2  = 1'b1;
      S_DECIDE: cmd.decide = 1'b1;
      S_MUL1:   cmd.mul1   = 1'b1;
      S_MUL2:   cmd.mul2   = 1'b1;
      S_MUL3:   cmd.mul3   = 1'b1;
      S_FINISH: cmd.finish = !stat.out_busy;
      default:  cmd = '0;
    endcase
  end

endmodule

// ===== src/gprl_datapath.sv =====
// Datapath: CORDIC vectoring unit, distance and heading checks, gain
// multipliers, ramps, clamps, speed state and the result register. Uses gprl_pkg.
module gprl_datapath import gprl_pkg::*; #(
  parameter int COORD_BITS   = COORD_BITS_DEF,
  parameter int ANGLE_BITS   = ANGLE_BITS_DEF,
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  dp_cmd_t               cmd,
  output dp_stat_t              stat,
  input  cfg_t                  cfg,
  input  logic                  mode,
  input  logic [COORD_BITS-1:0] target_x_mm,
  input  logic [COORD_BITS-1:0] target_y_mm,
  input  logic [COORD_BITS-1:0] robot_x_mm,
  input  logic [COORD_BITS-1:0] robot_y_mm,
  input  logic [ANGLE_BITS-1:0] robot_heading,
  input  logic [ANGLE_BITS-1:0] target_heading,
  input  logic                  mirror_y,
  input  logic                  stop_short,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [11:0]           trans_cmd,
  output logic                  trans_written,
  output logic [15:0]           rot_cmd,
  output logic [1:0]            status
);

  localparam int EW    = COORD_BITS + 1;
  localparam int DW    = COORD_BITS + 1;
  localparam int GUARD = SCALE_BITS - COORD_BITS;
  localparam int SW    = $clog2(CORDIC_STEPS);
  localparam int PW    = XW - 1 + 16;
  localparam int TPW   = 16 + DW;
  localparam int TW    = TPW - 12;
  localparam int MPW   = ANGLE_BITS + 29;
  localparam int RW    = 22;
  localparam logic signed [ANGLE_BITS-1:0] QTR = ANGLE_BITS'(2 ** (ANGLE_BITS - 3));

  logic                         mode_r, stop_r, zero_r;
  logic [ANGLE_BITS-1:0]        head_r, thead_r, bear;
  logic signed [EW-1:0]         ex, ey;
  logic signed [XW-1:0]         x, y;
  logic [31:0]                  z;
  logic [SW-1:0]                i;
  logic [PW-1:0]                prod;
  logic [DW-1:0]                span, d2;
  logic                         wall_hit, arrived, inzone;
  logic signed [ANGLE_BITS-1:0] err;
  logic [TPW-1:0]               tprod;
  logic [MPW-1:0]               mprod;
  logic [MRAD_W-1:0]            mrad;
  logic [11:0]                  tr;
  logic [ROTP_W-1:0]            rprod;
  logic [11:0]                  last_t;
  logic signed [15:0]           last_r;

  logic signed [EW-1:0]         ex_d, ey_d;
  logic signed [XW-1:0]         xs, ys, dx, dy;
  logic [PW-1:0]                dsum;
  logic [31:0]                  zsum;
  logic [DW-1:0]                dm;
  logic [ANGLE_BITS-1:0]        e;
  logic [ANGLE_BITS-1:0]        mag;
  logic [MPW-1:0]               msum;
  logic [TW-1:0]                tv, tlim, t1;
  logic signed [RW-1:0]         rs, rlim, r1, r2, r3;

  assign stat.iter_last = (i == SW'(CORDIC_STEPS - 1));
  assign stat.out_busy  = out_valid && !out_ready;

  always_comb begin
    ex_d = {target_x_mm[COORD_BITS-1], target_x_mm} - {robot_x_mm[COORD_BITS-1], robot_x_mm};
    ey_d = {target_y_mm[COORD_BITS-1], target_y_mm} - {robot_y_mm[COORD_BITS-1], robot_y_mm};
    xs   = {{(XW-EW){ex[EW-1]}}, ex} <<< GUARD;
    ys   = {{(XW-EW){ey[EW-1]}}, ey} <<< GUARD;
    dx   = y >>> i;
    dy   = x >>> i;
    dsum = prod + (PW'(1) << (15 + GUARD));
    zsum = z + (32'd1 << (31 - ANGLE_BITS));
    dm   = stop_r ? span - DW'(cfg.wall_offset_mm) : span;
    e    = (mode_r ? thead_r : bear) - head_r;
    mag  = err[ANGLE_BITS-1] ? ANGLE_BITS'(-err) : ANGLE_BITS'(err);
    msum = mprod + (MPW'(1) << (15 + ANGLE_BITS));
    tv   = TW'(tprod >> 12);
    tlim = TW'(last_t) + TW'(cfg.trans_step);
    t1   = (tv > tlim) ? tlim : tv;
    rs   = err[ANGLE_BITS-1] ? -RW'(rprod[ROTP_W-1:8]) : RW'(rprod[ROTP_W-1:8]);
    rlim = RW'(last_r) + RW'(cfg.rot_step);
    r1   = (rs > rlim) ? rlim : rs;
    r2   = (r1 > $signed(RW'(cfg.rot_limit))) ? $signed(RW'(cfg.rot_limit)) : r1;
    r3   = (r2 < -RW'(32768)) ? -RW'(32768) : r2;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r  <= mode;
      stop_r  <= stop_short;
      head_r  <= robot_heading;
      thead_r <= target_heading;
      ex      <= ex_d;
      ey      <= mirror_y ? -ey_d : ey_d;
    end
    if (cmd.prep) begin
      zero_r <= (ex == '0) && (ey == '0);
      i      <= '0;
      if (xs < 0) begin
        x <= -xs;
        y <= -ys;
        z <= 32'h8000_0000;
      end else begin
        x <= xs;
        y <= ys;
        z <= 32'h0;
      end
    end
    if (cmd.iter) begin
      i <= i + 1'b1;
      if (!y[XW-1]) begin
        x <= x + dx;
        y <= y - dy;
        z <= z + atan_val(5'(i));
      end else begin
        x <= x - dx;
        y <= y + dy;
        z <= z - atan_val(5'(i));
      end
    end
    if (cmd.dist1) prod <= PW'(x[XW-2:0]) * PW'(INV_GAIN_Q16);
    if (cmd.dist2) begin
      span <= DW'(dsum >> (16 + GUARD));
      bear <= zero_r ? '0 : zsum[31 -: ANGLE_BITS];
    end
    if (cmd.decide) begin
      wall_hit <= stop_r && (span < DW'(cfg.wall_offset_mm));
      arrived  <= dm < DW'(cfg.arrive_radius_mm);
      d2       <= dm;
      err      <= e;
      inzone   <= ($signed(e) < QTR) && ($signed(e) > -QTR);
    end
    if (cmd.mul1) begin
      tprod <= TPW'(cfg.trans_gain) * TPW'(d2);
      mprod <= MPW'(mag) * MPW'(TWO_PI_MRAD_Q16);
    end
    if (cmd.mul2) begin
      mrad <= MRAD_W'(msum >> (16 + ANGLE_BITS));
      tr   <= (t1 > TW'(cfg.trans_limit)) ? cfg.trans_limit : t1[11:0];
    end
    if (cmd.mul3) rprod <= ROTP_W'(cfg.rot_gain) * ROTP_W'(mrad);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      last_t    <= '0;
      last_r    <= '0;
    end else begin
      if (cmd.finish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (cmd.finish) begin
        if (mode_r) begin
          last_r <= r3[15:0];
        end else if (!wall_hit && !arrived) begin
          last_r <= r3[15:0];
          if (inzone) last_t <= tr;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      if (mode_r) begin
        trans_cmd     <= '0;
        trans_written <= 1'b0;
        rot_cmd       <= r3[15:0];
        status        <= STAT_REGULATING;
      end else if (wall_hit || arrived) begin
        trans_cmd     <= '0;
        trans_written <= 1'b1;
        rot_cmd       <= '0;
        status        <= wall_hit ? STAT_AT_WALL : STAT_AT_TARGET;
      end else begin
        trans_cmd     <= inzone ? tr : 12'd0;
        trans_written <= inzone;
        rot_cmd       <= r3[15:0];
        status        <= STAT_REGULATING;
      end
    end
  end

endmodule

// ===== sim/gprl_checker.sv =====
`timescale 1ns / 100ps
// Checker for the go-to-point regulator: watches the request, result and config ports,
// predicts every result and compares all its fields at once. Depends on gprl_pkg, gprl_in_if
// and gprl_out_if.
module gprl_checker import gprl_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  gprl_in_if                     in_ch,
  gprl_out_if                    out_ch,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output int                     fails,
  output int                     pending
);

  typedef struct packed {
    logic [11:0] trans_cmd;
    logic        trans_written;
    logic [15:0] rot_cmd;
    logic [1:0]  status;
  } cmd_t;

  localparam int SHIFT = 43 - 18;

  localparam logic [31:0] ARCTAN [16] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D
  };

  cfg_t   cfg;
  longint prev_trans;
  longint prev_rot;
  cmd_t   cmd_q[$];

  assign pending = cmd_q.size();

  function automatic longint heading_err(input logic [15:0] want, input logic [15:0] have);
    logic [15:0] d;
    d = want - have;
    return longint'($signed(d));
  endfunction

  function automatic longint turn_cmd(input longint err);
    longint mag, mrad, r;
    mag = (err < 0) ? -err : err;
    mrad = (mag * 64'd411774832 + (64'sd1 <<< 31)) >>> 32;
    r = (longint'(cfg.rot_gain) * mrad) >>> 8;
    if (err < 0) r = -r;
    if (r > prev_rot + longint'(cfg.rot_step)) r = prev_rot + longint'(cfg.rot_step);
    if (r > longint'(cfg.rot_limit)) r = cfg.rot_limit;
    if (r < -32768) r = -32768;
    prev_rot = r;
    return r;
  endfunction

  function automatic cmd_t steer(
    input logic mode, input logic [17:0] tx, input logic [17:0] ty,
    input logic [17:0] rx, input logic [17:0] ry, input logic [15:0] hdg,
    input logic [15:0] thdg, input logic mirror, input logic short);
    cmd_t        c;
    longint      ex, ey, x, y, dx, dy, span, err, tr, rot;
    logic [31:0] z;
    logic [15:0] bearing;
    tr = 0;
    rot = 0;
    c = '0;
    if (mode) begin
      rot = turn_cmd(heading_err(thdg, hdg));
    end else begin
      ex = longint'($signed(tx)) - longint'($signed(rx));
      ey = longint'($signed(ty)) - longint'($signed(ry));
      if (mirror) ey = -ey;
      x = ex <<< SHIFT;
      y = ey <<< SHIFT;
      z = '0;
      if (x < 0) begin
        x = -x;
        y = -y;
        z = 32'h80000000;
      end
      for (int i = 0; i < 16; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (y >= 0) begin
          x += dx; y -= dy; z += ARCTAN[i];
        end else begin
          x -= dx; y += dy; z -= ARCTAN[i];
        end
      end
      span = (x * 39797 + (64'sd1 <<< (15 + SHIFT))) >>> (16 + SHIFT);
      z += 32'h00008000;
      bearing = (ex == 0 && ey == 0) ? 16'd0 : z[31:16];
      c.trans_written = 1'b1;
      if (short && span < longint'(cfg.wall_offset_mm)) begin
        c.status = STAT_AT_WALL;
      end else begin
        if (short) span -= longint'(cfg.wall_offset_mm);
        if (span < longint'(cfg.arrive_radius_mm)) begin
          c.status = STAT_AT_TARGET;
        end else begin
          err = heading_err(bearing, hdg);
          if (err < 8192 && err > -8192) begin
            tr = (longint'(cfg.trans_gain) * span) >>> 12;
            if (tr > prev_trans + longint'(cfg.trans_step))
              tr = prev_trans + longint'(cfg.trans_step);
            if (tr > longint'(cfg.trans_limit)) tr = cfg.trans_limit;
            prev_trans = tr;
          end else begin
            c.trans_written = 1'b0;
          end
          rot = turn_cmd(err);
        end
      end
    end
    c.trans_cmd = tr[11:0];
    c.rot_cmd = rot[15:0];
    return c;
  endfunction

  always @(posedge clk) begin
    cmd_t got, want;
    if (rst) begin
      cfg <= '{16'd512, 16'd256, 12'd100, 12'd350, 12'd3000, 8'd15, 15'd1571, 10'd100};
      prev_trans = 0;
      prev_rot = 0;
      cmd_q.delete();
      fails <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          REG_TRANS_GAIN:  cfg.trans_gain <= cfg_data;
          REG_ROT_GAIN:    cfg.rot_gain <= cfg_data;
          REG_ARRIVE:      cfg.arrive_radius_mm <= cfg_data[11:0];
          REG_WALL:        cfg.wall_offset_mm <= cfg_data[11:0];
          REG_TRANS_LIMIT: cfg.trans_limit <= cfg_data[11:0];
          REG_TRANS_STEP:  cfg.trans_step <= cfg_data[7:0];
          REG_ROT_LIMIT:   cfg.rot_limit <= cfg_data[14:0];
          REG_ROT_STEP:    cfg.rot_step <= cfg_data[9:0];
          default: ;
        endcase
      end
      if (out_ch.valid && out_ch.ready) begin
        got = '{out_ch.trans_cmd, out_ch.trans_written, out_ch.rot_cmd, out_ch.status};
        if (cmd_q.size() == 0) begin
          if (fails < 10) $display("unexpected result %p", got);
          fails <= fails + 1;
        end else begin
          want = cmd_q.pop_front();
          if (got !== want) begin
            if (fails < 10) $display("expected %p got %p", want, got);
            fails <= fails + 1;
          end
        end
      end
      if (in_ch.valid && in_ch.ready)
        cmd_q.push_back(steer(in_ch.mode, in_ch.target_x_mm, in_ch.target_y_mm,
                              in_ch.robot_x_mm, in_ch.robot_y_mm, in_ch.robot_heading,
                              in_ch.target_heading, in_ch.mirror_y, in_ch.stop_short));
    end
  end

endmodule

// ===== sim/goto_point_rate_limited_regulator_core_tb.sv =====
`timescale 1ns / 100ps
// Testbench top for the go-to-point regulator: clock, reset, config phases, directed and
// random requests with random stalls. Depends on gprl_pkg, the channel interfaces,
// gprl_checker and the block.
module goto_point_rate_limited_regulator_core_tb import gprl_pkg::*;;

  localparam int LIMIT = 3000000;

  typedef struct {
    logic        mode;
    logic [17:0] tx, ty, rx, ry;
    logic [15:0] hdg, thdg;
    logic        mirror, short;
  } pose_req_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  int fails, pending, cycles = 0, stall_mode = 0;

  gprl_in_if #(.COORD_BITS(18), .ANGLE_BITS(16)) in_ch ();
  gprl_out_if out_ch ();

  goto_point_rate_limited_regulator_core DUT (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  gprl_checker checker_i (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fails(fails), .pending(pending)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("goto_point_rate_limited_regulator_core: mismatch");
      $finish;
    end
  end

  // result stalls: phases of none, light and heavy back-pressure
  always @(posedge clk) begin
    if ($urandom_range(0, 299) == 0) stall_mode <= $urandom_range(0, 2);
    case (stall_mode)
      0: out_ch.ready <= 1'b1;
      1: out_ch.ready <= ($urandom_range(0, 3) != 0);
      default: out_ch.ready <= ($urandom_range(0, 29) == 0);
    endcase
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  task automatic send(input pose_req_t p);
    int g;
    in_ch.valid <= 1'b1;
    in_ch.mode <= p.mode;
    in_ch.target_x_mm <= p.tx;
    in_ch.target_y_mm <= p.ty;
    in_ch.robot_x_mm <= p.rx;
    in_ch.robot_y_mm <= p.ry;
    in_ch.robot_heading <= p.hdg;
    in_ch.target_heading <= p.thdg;
    in_ch.mirror_y <= p.mirror;
    in_ch.stop_short <= p.short;
    do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
    g = gap_len();
    if (g > 0) begin
      in_ch.valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic write_reg(input cfg_reg_t idx, input int val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= CFG_DATA_W'(val);
    @(posedge clk);
  endtask

  task automatic set_all(input int tg, rg, ar, wo, tl, ts, rl, rs);
    write_reg(REG_TRANS_GAIN, tg);
    write_reg(REG_ROT_GAIN, rg);
    write_reg(REG_ARRIVE, ar);
    write_reg(REG_WALL, wo);
    write_reg(REG_TRANS_LIMIT, tl);
    write_reg(REG_TRANS_STEP, ts);
    write_reg(REG_ROT_LIMIT, rl);
    write_reg(REG_ROT_STEP, rs);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  function automatic pose_req_t mk(input int mode, input int tx, ty, rx, ry,
                                   input int hdg, thdg, input int mirror, short);
    pose_req_t p;
    p.mode = 1'(mode); p.tx = 18'(tx); p.ty = 18'(ty); p.rx = 18'(rx); p.ry = 18'(ry);
    p.hdg = 16'(hdg); p.thdg = 16'(thdg); p.mirror = 1'(mirror); p.short = 1'(short);
    return p;
  endfunction

  function automatic pose_req_t rand_req();
    pose_req_t p;
    int r, d;
    p.mode = ($urandom_range(0, 4) == 0);
    p.rx = 18'($urandom);
    p.ry = 18'($urandom);
    p.hdg = 16'($urandom);
    p.thdg = 16'($urandom);
    p.mirror = 1'($urandom_range(0, 1));
    p.short = 1'($urandom_range(0, 1));
    r = $urandom_range(0, 9);
    if (r == 0) begin
      p.tx = 18'($urandom);
      p.ty = 18'($urandom);
    end else if (r < 6) begin
      // well-aimed move: target ahead along x, heading near bearing
      d = (r < 3) ? $urandom_range(0, 800) : $urandom_range(0, 20000);
      p.tx = 18'(int'($signed(p.rx)) + d);
      p.ty = 18'(int'($signed(p.ry)) + $signed($urandom_range(0, 400)) - 200);
      p.mirror = 1'b0;
      p.hdg = 16'($signed($urandom_range(0, 12000)) - 6000);
    end else begin
      p.tx = 18'(int'($signed(p.rx)) + $signed($urandom_range(0, 8000)) - 4000);
      p.ty = 18'(int'($signed(p.ry)) + $signed($urandom_range(0, 8000)) - 4000);
    end
    return p;
  endfunction

  initial begin
    in_ch.valid = 1'b0;
    in_ch.mode = 1'b0;
    in_ch.target_x_mm = '0;
    in_ch.target_y_mm = '0;
    in_ch.robot_x_mm = '0;
    in_ch.robot_y_mm = '0;
    in_ch.robot_heading = '0;
    in_ch.target_heading = '0;
    in_ch.mirror_y = 1'b0;
    in_ch.stop_short = 1'b0;
    out_ch.ready = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    set_all(512, 256, 100, 350, 3000, 15, 1571, 100);
    send(mk(0, 0, 0, 0, 0, 0, 0, 0, 0));
    send(mk(0, 50, 0, 0, 0, 0, 0, 0, 0));
    send(mk(0, 300, 0, 0, 0, 0, 0, 0, 1));
    send(mk(0, 400, 0, 0, 0, 0, 0, 0, 1));
    send(mk(0, 2000, 0, 0, 0, 0, 0, 0, 1));
    send(mk(0, 3000, 0, 0, 0, 8191, 0, 0, 0));
    send(mk(0, 3000, 0, 0, 0, 8192, 0, 0, 0));
    send(mk(0, 3000, 0, 0, 0, 16'hE001, 0, 0, 0));
    send(mk(0, 3000, 0, 0, 0, 16'hE000, 0, 0, 0));
    send(mk(0, 131071, 131071, -131072, -131072, 8192, 0, 0, 0));
    send(mk(0, -131072, -131072, 131071, 131071, 16'hA000, 0, 1, 0));
    send(mk(0, -131072, 131071, 131071, -131072, 16'h6000, 0, 1, 1));
    send(mk(0, 0, 5000, 0, 0, 16384, 0, 1, 0));
    send(mk(0, -5000, 0, 0, 0, 32768, 0, 0, 0));
    send(mk(1, 0, 0, 0, 0, 0, 32768, 0, 0));
    send(mk(1, 0, 0, 0, 0, 0, 32767, 1, 1));
    send(mk(1, 0, 0, 0, 0, 65535, 0, 0, 0));
    send(mk(1, 0, 0, 0, 0, 16'h8001, 16'h0000, 0, 0));
    send(mk(1, 0, 0, 0, 0, 0, 0, 0, 0));
    drain();

    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: set_all(65535, 65535, 4095, 4095, 4095, 255, 32767, 1023);
        1: set_all(0, 0, 0, 0, 0, 0, 0, 0);
        2: set_all(16384, 4096, 10, 200, 4095, 255, 32767, 1023);
        3: set_all(512, 256, 100, 350, 3000, 15, 1571, 100);
        default: set_all($urandom, $urandom, $urandom_range(0, 4095), $urandom_range(0, 4095),
                         $urandom_range(0, 4095), $urandom_range(0, 255),
                         $urandom_range(0, 32767), $urandom_range(0, 1023));
      endcase
      for (int n = 0; n < 350; n++) send(rand_req());
      drain();
    end

    if (fails == 0)
      $display("goto_point_rate_limited_regulator_core: match");
    else
      $display("goto_point_rate_limited_regulator_core: mismatch");
    $finish;
  end

endmodule

// ===== files.f =====
src/gprl_pkg.sv
src/gprl_in_if.sv
src/gprl_out_if.sv
src/gprl_ctrl.sv
src/gprl_datapath.sv
src/goto_point_rate_limited_regulator_core.sv
sim/gprl_checker.sv
sim/goto_point_rate_limited_regulator_core_tb.sv
